// ----- rtl/wgd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wgd_pkg;

   localparam logic       OP_CHECK = 1'b0;
   localparam logic       OP_SLEEP = 1'b1;

   localparam int         CSR_INDEX_WIDTH = 2;
   localparam int         CSR_DATA_WIDTH  = 15;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_SECONDS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_NEEDED    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_NEEDED      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILT_THRESHOLD = 2'd3;

   localparam logic [5:0]  RST_WINDOW_SECONDS = 6'd3;
   localparam logic [3:0]  RST_DOWN_NEEDED    = 4'd2;
   localparam logic [3:0]  RST_UP_NEEDED      = 4'd3;
   localparam logic [14:0] RST_TILT_THRESHOLD = 15'd5;

   localparam logic [15:0] SEC_PER_HOUR     = 16'd3600;
   localparam logic [15:0] SEC_PER_MINUTE   = 16'd60;
   localparam logic [16:0] HALF_DAY_SECONDS = 17'd43200;
   localparam logic [7:0]  COUNT_MAX        = 8'd255;

   typedef struct packed {
      logic               op;
      logic [3:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic signed [15:0] accel_z;
      logic               motion_wake;
   } wgd_item_type;

   typedef struct packed {
      logic [5:0]  window_seconds;
      logic [3:0]  down_needed;
      logic [3:0]  up_needed;
      logic [14:0] tilt_threshold;
   } wgd_cfg_type;

   typedef struct packed {
      logic wake;
      logic in_deep_sleep;
   } wgd_result_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] count);
      return (count == COUNT_MAX) ? COUNT_MAX : count + 8'd1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/wgd_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wgd_csr
   import wgd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   output      wgd_cfg_type                cfg
);

   wgd_cfg_type cfg_ff;
   wgd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_SECONDS: cfg_in.window_seconds = csr_wr_data[5:0];
            CSR_DOWN_NEEDED:    cfg_in.down_needed    = csr_wr_data[3:0];
            CSR_UP_NEEDED:      cfg_in.up_needed      = csr_wr_data[3:0];
            CSR_TILT_THRESHOLD: cfg_in.tilt_threshold = csr_wr_data[14:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_seconds <= RST_WINDOW_SECONDS;
         cfg_ff.down_needed    <= RST_DOWN_NEEDED;
         cfg_ff.up_needed      <= RST_UP_NEEDED;
         cfg_ff.tilt_threshold <= RST_TILT_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/wgd_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wgd_engine
   import wgd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire wgd_item_type  item,
   input  wire wgd_cfg_type   cfg,
   output wgd_result_type     result
);

   logic        deep_mode_ff,  deep_mode_in;
   logic [15:0] last_stamp_ff, last_stamp_in;
   logic [7:0]  down_count_ff, down_count_in;
   logic [7:0]  up_count_ff,   up_count_in;

   logic [15:0]        stamp;
   logic [16:0]        stamp_adj;
   logic signed [17:0] delta;
   logic               in_window;
   logic signed [16:0] z_ext;
   logic signed [16:0] thr_ext;
   logic               face_down;
   logic               face_up;
   logic               wake;

   always_comb begin
      stamp = 16'(item.hour) * SEC_PER_HOUR + 16'(item.minute) * SEC_PER_MINUTE
            + 16'(item.second);
      stamp_adj = (stamp < last_stamp_ff) ? {1'b0, stamp} + HALF_DAY_SECONDS
                                          : {1'b0, stamp};
      delta     = $signed({1'b0, stamp_adj}) - $signed({2'b00, last_stamp_ff});
      in_window = delta < $signed({12'd0, cfg.window_seconds});
      z_ext     = 17'(item.accel_z);
      thr_ext   = $signed({2'b00, cfg.tilt_threshold});
      face_down = z_ext < -thr_ext;
      face_up   = z_ext > thr_ext;
   end

   always_comb begin
      deep_mode_in  = deep_mode_ff;
      last_stamp_in = last_stamp_ff;
      down_count_in = down_count_ff;
      up_count_in   = up_count_ff;
      wake          = 1'b0;
      if (item.op == OP_SLEEP) begin
         deep_mode_in  = 1'b1;
         down_count_in = 8'd0;
         up_count_in   = 8'd0;
      end else if (!deep_mode_ff) begin
         wake = item.motion_wake;
      end else begin
         if (in_window) begin
            if (face_down) begin
               down_count_in = sat_inc(down_count_ff);
            end else if (face_up && down_count_ff >= 8'(cfg.down_needed)) begin
               up_count_in = sat_inc(up_count_ff);
            end
            if (down_count_in >= 8'(cfg.down_needed) &&
                up_count_in >= 8'(cfg.up_needed)) begin
               wake         = 1'b1;
               deep_mode_in = 1'b0;
            end
         end else begin
            down_count_in = 8'd1;
            up_count_in   = 8'd0;
         end
         last_stamp_in = stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deep_mode_ff  <= 1'b0;
         last_stamp_ff <= 16'd0;
         down_count_ff <= 8'd0;
         up_count_ff   <= 8'd0;
      end else if (advance) begin
         deep_mode_ff  <= deep_mode_in;
         last_stamp_ff <= last_stamp_in;
         down_count_ff <= down_count_in;
         up_count_ff   <= up_count_in;
      end
   end

   assign result = {wake, deep_mode_in};

endmodule

`default_nettype wire

// ----- rtl/deep_sleep_wake_gesture_detector_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A request passes through the input register and then the result register to rsp_valid.
// Throughput: one item per cycle unless the result register stalls; the gesture state updates as an item moves
// from the input register into the result register.
// A full result register that is not taken stalls the input register in place.
// Reset (synchronous): both channels empty, not in deep sleep, counters and
// last stamp zero, registers back to their defaults.

module deep_sleep_wake_gesture_detector_unit
   import wgd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic                       req_op,
   input  wire logic [3:0]                 req_hour,
   input  wire logic [5:0]                 req_minute,
   input  wire logic [5:0]                 req_second,
   input  wire logic signed [15:0]         req_accel_z,
   input  wire logic                       req_motion_wake,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic                       rsp_wake,
   output      logic                       rsp_in_deep_sleep
);

   wgd_cfg_type    cfg;
   wgd_item_type   item_ff;
   wgd_result_type step_result;
   wgd_result_type result_ff;
   logic           item_valid_ff;
   logic           rsp_valid_ff;
   logic           advance;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   wgd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   wgd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.op          <= req_op;
         item_ff.hour        <= req_hour;
         item_ff.minute      <= req_minute;
         item_ff.second      <= req_second;
         item_ff.accel_z     <= req_accel_z;
         item_ff.motion_wake <= req_motion_wake;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wake          = result_ff.wake;
   assign rsp_in_deep_sleep = result_ff.in_deep_sleep;

endmodule

`default_nettype wire

// ----- rtl/wgd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wgd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_wake,
   input wire logic rsp_in_deep_sleep
);

   // a wake always leaves deep sleep
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_wake && rsp_in_deep_sleep))
      else $error("wake reported while still in deep sleep");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wake)
                                 && $stable(rsp_in_deep_sleep))
      else $error("stalled result changed");

endmodule

bind deep_sleep_wake_gesture_detector_unit wgd_checker u_wgd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_wake          (rsp_wake),
   .rsp_in_deep_sleep (rsp_in_deep_sleep)
);

`default_nettype wire

// ----- verif/wake_gesture_checker.sv -----
`timescale 1ns / 1ps

module wake_gesture_checker
   import wgd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_op,
   input  logic [3:0]                 req_hour,
   input  logic [5:0]                 req_minute,
   input  logic [5:0]                 req_second,
   input  logic signed [15:0]         req_accel_z,
   input  logic                       req_motion_wake,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_wake,
   input  logic                       rsp_in_deep_sleep,
   output int                         fail_count,
   output int                         pending_count,
   output int                         checked_count,
   output int                         wake_count
);

   wgd_cfg_type    gesture_cfg;
   logic           deep_mode;
   logic [15:0]    last_stamp;
   logic [7:0]     down_count;
   logic [7:0]     up_count;
   wgd_result_type verdict_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      wake_count    = 0;
   end

   // one tap / sleep command applied to the mirrored gesture state
   task automatic advance_gesture(input wgd_item_type it, output wgd_result_type res);
      int now_s;
      int prev_s;
      int adj_s;
      int z_val;
      int thr;
      res.wake = 1'b0;
      if (it.op == OP_SLEEP) begin
         deep_mode  = 1'b1;
         down_count = 8'd0;
         up_count   = 8'd0;
      end else if (!deep_mode) begin
         res.wake = it.motion_wake;
      end else begin
         now_s  = 3600 * int'(it.hour) + 60 * int'(it.minute) + int'(it.second);
         prev_s = int'(last_stamp);
         adj_s  = now_s;
         z_val  = int'($signed(it.accel_z));
         thr    = int'(gesture_cfg.tilt_threshold);
         if (adj_s < prev_s)
            adj_s = adj_s + 43200;
         if (adj_s - prev_s < int'(gesture_cfg.window_seconds)) begin
            if (z_val < -thr) begin
               if (down_count != 8'hFF)
                  down_count = down_count + 8'd1;
            end else if (z_val > thr && down_count >= {4'd0, gesture_cfg.down_needed}) begin
               if (up_count != 8'hFF)
                  up_count = up_count + 8'd1;
            end
            if (down_count >= {4'd0, gesture_cfg.down_needed} &&
                up_count >= {4'd0, gesture_cfg.up_needed}) begin
               res.wake  = 1'b1;
               deep_mode = 1'b0;
            end
         end else begin
            down_count = 8'd1;
            up_count   = 8'd0;
         end
         last_stamp = now_s[15:0];
      end
      res.in_deep_sleep = deep_mode;
   endtask

   always @(posedge clock) begin
      wgd_item_type   it;
      wgd_result_type want;
      if (reset) begin
         gesture_cfg.window_seconds = RST_WINDOW_SECONDS;
         gesture_cfg.down_needed    = RST_DOWN_NEEDED;
         gesture_cfg.up_needed      = RST_UP_NEEDED;
         gesture_cfg.tilt_threshold = RST_TILT_THRESHOLD;
         deep_mode  = 1'b0;
         last_stamp = 16'd0;
         down_count = 8'd0;
         up_count   = 8'd0;
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (verdict_q.size() == 0) begin
               $error("rsp transfer with nothing pending: wake %0b in_deep_sleep %0b",
                      rsp_wake, rsp_in_deep_sleep);
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_wake !== want.wake) begin
                  $error("wake: expected %0b, actual %0b", want.wake, rsp_wake);
                  fail_count++;
               end
               if (rsp_in_deep_sleep !== want.in_deep_sleep) begin
                  $error("in_deep_sleep: expected %0b, actual %0b",
                         want.in_deep_sleep, rsp_in_deep_sleep);
                  fail_count++;
               end
               if (rsp_wake === 1'b1)
                  wake_count++;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW_SECONDS: gesture_cfg.window_seconds = csr_wr_data[5:0];
               CSR_DOWN_NEEDED:    gesture_cfg.down_needed    = csr_wr_data[3:0];
               CSR_UP_NEEDED:      gesture_cfg.up_needed      = csr_wr_data[3:0];
               CSR_TILT_THRESHOLD: gesture_cfg.tilt_threshold = csr_wr_data[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            it.op          = req_op;
            it.hour        = req_hour;
            it.minute      = req_minute;
            it.second      = req_second;
            it.accel_z     = req_accel_z;
            it.motion_wake = req_motion_wake;
            advance_gesture(it, want);
            verdict_q.push_back(want);
         end
      end
      pending_count = verdict_q.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import wgd_pkg::*;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_op;
   logic [3:0]                 req_hour;
   logic [5:0]                 req_minute;
   logic [5:0]                 req_second;
   logic signed [15:0]         req_accel_z;
   logic                       req_motion_wake;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_wake;
   logic                       rsp_in_deep_sleep;

   int          fail_count;
   int          pending_count;
   int          checked_count;
   int          wake_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_off_req;
   int          sent_count;
   int          setting_count;
   int          tod;
   wgd_cfg_type cfg_now;

   deep_sleep_wake_gesture_detector_unit dut (.*);

   wake_gesture_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("timeout with %0d results pending", pending_count);
      $display("[deep_sleep_wake_gesture_detector_unit] ERROR");
      $finish;
   end

   // receiver: random ready, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            for (int c = 0; c < 120; c++)
               @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic wgd_item_type make_item(input logic op, input int hr, input int mn,
                                              input int sc, input int z, input logic motion);
      wgd_item_type it;
      it.op          = op;
      it.hour        = hr[3:0];
      it.minute      = mn[5:0];
      it.second      = sc[5:0];
      it.accel_z     = z[15:0];
      it.motion_wake = motion;
      return it;
   endfunction

   task automatic offer(input wgd_item_type it);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= it.op;
      req_hour        <= it.hour;
      req_minute      <= it.minute;
      req_second      <= it.second;
      req_accel_z     <= it.accel_z;
      req_motion_wake <= it.motion_wake;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   task automatic apply_settings(input int win, input int dn, input int upn, input int tilt);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_WINDOW_SECONDS;
      csr_wr_data <= win[14:0];
      @(posedge clock);
      csr_index   <= CSR_DOWN_NEEDED;
      csr_wr_data <= dn[14:0];
      @(posedge clock);
      csr_index   <= CSR_UP_NEEDED;
      csr_wr_data <= upn[14:0];
      @(posedge clock);
      csr_index   <= CSR_TILT_THRESHOLD;
      csr_wr_data <= tilt[14:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_now.window_seconds = win[5:0];
      cfg_now.down_needed    = dn[3:0];
      cfg_now.up_needed      = upn[3:0];
      cfg_now.tilt_threshold = tilt[14:0];
      setting_count++;
   endtask

   // sleep, face-down taps, face-up taps, a few plain checks; repeated
   task automatic gesture_batch(input int n);
      int   stage;
      int   left;
      int   win;
      int   thr;
      int   dt;
      int   z;
      int   hr;
      int   mn;
      int   sc;
      logic op;
      stage = 0;
      left  = 0;
      for (int k = 0; k < n; k++) begin
         win = int'(cfg_now.window_seconds);
         thr = int'(cfg_now.tilt_threshold);
         op  = OP_CHECK;
         if ($urandom_range(99) < 6) begin
            op = 1'($urandom_range(1));
            hr = $urandom_range(15);
            mn = $urandom_range(63);
            sc = $urandom_range(63);
            z  = int'($urandom_range(65535)) - 32768;
         end else if (stage == 0) begin
            op    = OP_SLEEP;
            hr    = $urandom_range(15);
            mn    = $urandom_range(63);
            sc    = $urandom_range(63);
            z     = int'($urandom_range(65535)) - 32768;
            stage = 1;
            left  = int'(cfg_now.down_needed) + int'($urandom_range(2));
         end else begin
            if ($urandom_range(9) < 8)
               dt = $urandom_range(win > 0 ? win - 1 : 0);
            else
               dt = win + int'($urandom_range(200));
            if ($urandom_range(49) == 0)
               dt = $urandom_range(43199);
            tod = (tod + dt) % 43200;
            hr  = tod / 3600;
            mn  = (tod / 60) % 60;
            sc  = tod % 60;
            if ($urandom_range(29) == 0) begin
               hr = $urandom_range(15);
               mn = $urandom_range(63);
               sc = $urandom_range(63);
            end
            if ($urandom_range(99) < 15 || stage == 3)
               z = int'($urandom_range(2 * thr)) - thr;
            else if (stage == 1)
               z = -(thr + 1 + int'($urandom_range(32767 - thr)));
            else if (thr == 32767)
               z = 32767;
            else
               z = thr + 1 + int'($urandom_range(32766 - thr));
            case (stage)
               1: if (left <= 1) begin
                     stage = 2;
                     left  = int'(cfg_now.up_needed) + int'($urandom_range(1));
                  end else begin
                     left--;
                  end
               2: if (left <= 1) begin
                     stage = 3;
                     left  = $urandom_range(3);
                  end else begin
                     left--;
                  end
               default: if (left <= 1) stage = 0; else left--;
            endcase
         end
         offer(make_item(op, hr, mn, sc, z, 1'($urandom_range(1))));
      end
   endtask

   initial begin
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_WINDOW_SECONDS;
      csr_wr_data     <= '0;
      req_valid       <= 1'b0;
      req_op          <= OP_CHECK;
      req_hour        <= '0;
      req_minute      <= '0;
      req_second      <= '0;
      req_accel_z     <= '0;
      req_motion_wake <= 1'b0;
      send_idle_pct = 26;
      recv_idle_pct = 64;
      hold_off_req  = 1'b0;
      sent_count    = 0;
      setting_count = 1;
      tod           = 0;
      cfg_now.window_seconds = RST_WINDOW_SECONDS;
      cfg_now.down_needed    = RST_DOWN_NEEDED;
      cfg_now.up_needed      = RST_UP_NEEDED;
      cfg_now.tilt_threshold = RST_TILT_THRESHOLD;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      offer(make_item(OP_CHECK, 0, 0, 0, 0, 1'b1));
      offer(make_item(OP_CHECK, 15, 63, 63, -1, 1'b0));
      offer(make_item(OP_SLEEP, 0, 0, 0, 32767, 1'b1));
      offer(make_item(OP_CHECK, 0, 0, 0, -32768, 1'b1));
      offer(make_item(OP_CHECK, 0, 0, 1, -6, 1'b0));
      offer(make_item(OP_CHECK, 0, 0, 2, 32767, 1'b0));
      offer(make_item(OP_CHECK, 0, 0, 3, 6, 1'b1));
      offer(make_item(OP_CHECK, 0, 0, 4, 5, 1'b0));
      offer(make_item(OP_CHECK, 0, 0, 5, -5, 1'b1));
      offer(make_item(OP_CHECK, 0, 0, 6, 6, 1'b0));
      offer(make_item(OP_CHECK, 0, 0, 7, 0, 1'b1));
      offer(make_item(OP_SLEEP, 5, 30, 30, 0, 1'b0));
      // out of window restarts, then rollover past the half day
      offer(make_item(OP_CHECK, 11, 59, 59, -100, 1'b1));
      offer(make_item(OP_CHECK, 0, 0, 1, 200, 1'b0));
      offer(make_item(OP_CHECK, 0, 0, 2, -100, 1'b1));
      offer(make_item(OP_CHECK, 0, 0, 3, 7, 1'b0));
      // largest raw stamp, then a tap whose difference stays negative
      offer(make_item(OP_CHECK, 15, 63, 63, -100, 1'b0));
      offer(make_item(OP_CHECK, 0, 0, 0, -100, 1'b1));
      offer(make_item(OP_CHECK, 0, 0, 1, 9, 1'b0));

      // down counter saturation
      apply_settings(60, 15, 15, 0);
      offer(make_item(OP_SLEEP, 3, 3, 3, 0, 1'b0));
      repeat (270) offer(make_item(OP_CHECK, 3, 3, 3, -1 - int'($urandom_range(32767)),
                                   1'($urandom_range(1))));
      repeat (16) offer(make_item(OP_CHECK, 3, 3, 4, 1 + int'($urandom_range(32766)),
                                  1'($urandom_range(1))));

      apply_settings(0, 0, 0, 32767);
      gesture_batch(120);
      apply_settings(5, 2, 3, 1000);
      gesture_batch(160);

      send_idle_pct = 64;
      recv_idle_pct = 26;
      apply_settings(63, 1, 15, 100);
      gesture_batch(160);
      apply_settings(1, 0, 1, 0);
      gesture_batch(160);
      apply_settings($urandom_range(60, 1), $urandom_range(15), $urandom_range(15),
                     $urandom_range(32767));
      gesture_batch(160);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(10, 3, 4, 16000);
      hold_off_req = 1'b1;
      gesture_batch(160);
      apply_settings($urandom_range(60, 1), $urandom_range(6), $urandom_range(6),
                     $urandom_range(32767));
      gesture_batch(100);

      settle();
      repeat (10) @(posedge clock);
      $display("Covered %0d requests over %0d register settings; %0d responses checked, %0d wakes.",
               sent_count, setting_count, checked_count, wake_count);
      if (fail_count == 0 && pending_count == 0)
         $display("[deep_sleep_wake_gesture_detector_unit] OK");
      else
         $display("[deep_sleep_wake_gesture_detector_unit] ERROR");
      $finish;
   end

endmodule
